// ----- sv/tacc_pkg.sv -----
// Shared types and constants for the tree ancestor closure counter.
`timescale 1ns / 1ps
`default_nettype none
package tacc_pkg;

    localparam int NODE_W    = 10;
    localparam int DEPTH     = 1024;
    localparam int COUNT_W   = 11;
    localparam int MAX_NODES = 1024;
    localparam int LEN_W     = $clog2(MAX_NODES + 1);

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_QUERY   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent_node;
    } in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] visited_count;
        logic               walk_error;
    } out_t;

    typedef struct packed {
        logic [NODE_W-1:0] raddr;
        logic              par_we;
        logic [NODE_W-1:0] par_waddr;
        logic [NODE_W-1:0] par_wdata;
        logic              mark_we;
        logic [NODE_W-1:0] mark_waddr;
        logic              mark_wdata;
    } mem_req_t;

endpackage
`default_nettype wire

// ----- sv/tacc_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/tacc_walk.sv -----
// Sequencer that loads parents, clears marks and walks parent chains.
`timescale 1ns / 1ps
`default_nettype none
module tacc_walk (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tacc_pkg::in_t                   s_data,
    output tacc_pkg::mem_req_t                   mem_req,
    input  wire logic [tacc_pkg::NODE_W-1:0]     parent_rdata,
    input  wire logic                            mark_rdata,
    output logic                                 res_valid,
    output tacc_pkg::out_t                       res_data,
    input  wire logic                            out_free
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [tacc_pkg::NODE_W-1:0]    cur_reg, cur_next;
    logic [tacc_pkg::NODE_W-1:0]    start_reg, start_next;
    logic [tacc_pkg::NODE_W-1:0]    clr_reg, clr_next;
    logic [tacc_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [tacc_pkg::COUNT_W-1:0]   total_reg, total_next;
    logic                           err_reg, err_next;
    logic                           marked;

    assign marked = (cur_reg == '0) || mark_rdata;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        clr_next   = clr_reg;
        len_next   = len_reg;
        total_next = total_reg;
        err_next   = err_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        mem_req    = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_req.mark_we    = 1'b1;
                mem_req.mark_waddr = clr_reg;
                mem_req.mark_wdata = 1'b0;
                clr_next = clr_reg + tacc_pkg::NODE_W'(1);
                if (clr_reg == tacc_pkg::NODE_W'(tacc_pkg::DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.req_type)
                        tacc_pkg::REQ_LOAD: begin
                            mem_req.par_we    = 1'b1;
                            mem_req.par_waddr = s_data.node;
                            mem_req.par_wdata = s_data.parent_node;
                        end
                        tacc_pkg::REQ_QUERY: begin
                            cur_next   = s_data.node;
                            start_next = s_data.node;
                            len_next   = '0;
                            state_next = ST_WALK;
                        end
                        tacc_pkg::REQ_RESTART: begin
                            total_next = tacc_pkg::COUNT_W'(1);
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (marked) begin
                    err_next = 1'b0;
                    if (len_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        total_next = total_reg + tacc_pkg::COUNT_W'(len_reg);
                        cur_next   = start_reg;
                        state_next = ST_MARK;
                    end
                end else if (len_reg >= tacc_pkg::LEN_W'(tacc_pkg::MAX_NODES)) begin
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    len_next = len_reg + tacc_pkg::LEN_W'(1);
                    cur_next = parent_rdata;
                end
            end
            ST_MARK: begin
                mem_req.mark_we    = 1'b1;
                mem_req.mark_waddr = cur_reg;
                mem_req.mark_wdata = 1'b1;
                cur_next = parent_rdata;
                len_next = len_reg - tacc_pkg::LEN_W'(1);
                if (len_reg == tacc_pkg::LEN_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                res_valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        mem_req.raddr = cur_next;
    end

    assign res_data.visited_count = total_reg;
    assign res_data.walk_error    = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            total_reg <= tacc_pkg::COUNT_W'(1);
            err_reg   <= 1'b0;
            cur_reg   <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            err_reg   <= err_next;
            cur_reg   <= cur_next;
            len_reg   <= len_next;
        end
        start_reg <= start_next;
    end

endmodule
`default_nettype wire

// ----- sv/tree_ancestor_closure_counter.sv -----
// Top level of the tree ancestor closure counter.
//
// Keeps a 1024-entry parent table and a 1024-entry visited-mark memory for a
// tree rooted at node 0. A load transfer gives no result. A restart starts a
// sweep that clears the whole mark memory, and the same sweep runs after
// reset; the input is not ready during it. A query walks its unmarked path
// with one parent read per step, first to measure the path and then to mark
// it, before its result is offered. The result sits in an output register;
// the next item is accepted while it waits. An unwritten parent entry must
// never be reached by a walk.
`timescale 1ns / 1ps
`default_nettype none
module tree_ancestor_closure_counter (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tacc_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tacc_pkg::out_t      m_data
);

    tacc_pkg::mem_req_t             mem_req;
    logic [tacc_pkg::NODE_W-1:0]    parent_rdata;
    logic                           mark_rdata;
    logic                           res_valid;
    tacc_pkg::out_t                 res_data;
    logic                           out_free;
    logic                           m_valid_reg;
    tacc_pkg::out_t                 m_data_reg;

    tacc_ram #(
        .WIDTH(tacc_pkg::NODE_W),
        .DEPTH(tacc_pkg::DEPTH)
    ) u_parent_ram (
        .aclk (aclk),
        .we   (mem_req.par_we),
        .waddr(mem_req.par_waddr),
        .wdata(mem_req.par_wdata),
        .raddr(mem_req.raddr),
        .rdata(parent_rdata)
    );

    tacc_ram #(
        .WIDTH(1),
        .DEPTH(tacc_pkg::DEPTH)
    ) u_mark_ram (
        .aclk (aclk),
        .we   (mem_req.mark_we),
        .waddr(mem_req.mark_waddr),
        .wdata(mem_req.mark_wdata),
        .raddr(mem_req.raddr),
        .rdata(mark_rdata)
    );

    tacc_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .mem_req     (mem_req),
        .parent_rdata(parent_rdata),
        .mark_rdata  (mark_rdata),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .out_free    (out_free)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && out_free) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- bench/tree_ancestor_closure_counter_tb.sv -----
// Self-checking testbench for the tree ancestor closure counter.
`timescale 1ns / 1ps
module tree_ancestor_closure_counter_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SCRIPT_LEN   = 24;
    localparam int RANDOM_ITEMS = 556;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 2 * tacc_pkg::MAX_NODES + 16;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [1:0]                   req_type;
        logic [tacc_pkg::NODE_W-1:0]  node;
        logic [tacc_pkg::NODE_W-1:0]  parent_node;
        bit                           typed;
        logic [tacc_pkg::COUNT_W-1:0] visited_count;
        logic                         walk_error;
    } tree_op_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    tacc_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    tacc_pkg::out_t m_data;

    logic [tacc_pkg::NODE_W-1:0]  tree_parent [tacc_pkg::DEPTH];
    bit                           parent_loaded [tacc_pkg::DEPTH];
    bit                           node_marked [tacc_pkg::DEPTH];
    logic [tacc_pkg::COUNT_W-1:0] mark_count;
    int                           chain_tip;

    tacc_pkg::out_t expected_counts [$];
    tree_op_t       directed_ops [SCRIPT_LEN];
    int             mismatches  = 0;
    int             cycle_count = 0;
    bit             send_burst  = 1'b0;

    tree_ancestor_closure_counter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit walk_is_safe(input logic [tacc_pkg::NODE_W-1:0] start);
        logic [tacc_pkg::NODE_W-1:0] cur;
        int                          steps;
        cur   = start;
        steps = 0;
        while (!node_marked[cur] && steps < tacc_pkg::MAX_NODES) begin
            if (!parent_loaded[cur]) return 1'b0;
            cur = tree_parent[cur];
            steps++;
        end
        return 1'b1;
    endfunction

    task automatic advance_tree(input tacc_pkg::in_t item, output bit has_count,
                                output tacc_pkg::out_t count);
        logic [tacc_pkg::NODE_W-1:0] cur;
        int                          path_len;
        logic                        overlong;
        has_count = 1'b0;
        count     = '0;
        case (item.req_type)
            tacc_pkg::REQ_LOAD: begin
                tree_parent[item.node]   = item.parent_node;
                parent_loaded[item.node] = 1'b1;
            end
            tacc_pkg::REQ_RESTART: begin
                foreach (node_marked[i]) node_marked[i] = 1'b0;
                node_marked[0] = 1'b1;
                mark_count     = tacc_pkg::COUNT_W'(1);
            end
            tacc_pkg::REQ_QUERY: begin
                cur      = item.node;
                path_len = 0;
                overlong = 1'b0;
                while (!node_marked[cur]) begin
                    if (path_len >= tacc_pkg::MAX_NODES) begin
                        overlong = 1'b1;
                        break;
                    end
                    path_len++;
                    cur = tree_parent[cur];
                end
                if (!overlong) begin
                    cur = item.node;
                    repeat (path_len) begin
                        node_marked[cur] = 1'b1;
                        mark_count++;
                        cur = tree_parent[cur];
                    end
                end
                has_count           = 1'b1;
                count.visited_count = mark_count;
                count.walk_error    = overlong;
            end
            default: ;
        endcase
    endtask

    task automatic offer(input tacc_pkg::in_t item, input bit typed,
                         input tacc_pkg::out_t typed_count);
        int             gap;
        bit             has_count;
        tacc_pkg::out_t count;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        advance_tree(item, has_count, count);
        if (has_count) expected_counts.push_back(typed ? typed_count : count);
        @(negedge aclk);
    endtask

    task automatic pick_random_item(output tacc_pkg::in_t item);
        int                          dice;
        int                          tries;
        bit                          found;
        logic [tacc_pkg::NODE_W-1:0] n;
        logic [tacc_pkg::NODE_W-1:0] p;
        dice             = $urandom_range(0, 99);
        item.node        = tacc_pkg::NODE_W'($urandom_range(0, tacc_pkg::DEPTH - 1));
        item.parent_node = tacc_pkg::NODE_W'($urandom_range(0, tacc_pkg::DEPTH - 1));
        if (dice < 4) begin
            item.req_type = tacc_pkg::REQ_RESTART;
        end else if (dice < 6) begin
            item.req_type = REQ_UNUSED;
        end else if (dice < 9) begin
            // broken load: may form a cycle or point at an unloaded node
            item.req_type = tacc_pkg::REQ_LOAD;
        end else if (dice < 52) begin
            item.req_type = tacc_pkg::REQ_LOAD;
            if ($urandom_range(0, 1) == 1 && chain_tip < tacc_pkg::DEPTH - 1) begin
                n = tacc_pkg::NODE_W'(chain_tip + 1);
                p = tacc_pkg::NODE_W'(chain_tip);
            end else begin
                n = tacc_pkg::NODE_W'($urandom_range(1, tacc_pkg::DEPTH - 1));
                p = tacc_pkg::NODE_W'($urandom_range(0, int'(n) - 1));
                if (!parent_loaded[p]) p = '0;
            end
            chain_tip        = int'(n);
            item.node        = n;
            item.parent_node = p;
        end else begin
            item.req_type = tacc_pkg::REQ_QUERY;
            found = 1'b0;
            for (tries = 0; tries < 8 && !found; tries++) begin
                if ($urandom_range(0, 1) == 1) n = tacc_pkg::NODE_W'(chain_tip);
                else n = tacc_pkg::NODE_W'($urandom_range(0, tacc_pkg::DEPTH - 1));
                found = walk_is_safe(n);
            end
            item.node = found ? n : '0;
        end
    endtask

    always @(posedge aclk) begin : count_check
        tacc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                $error("visited_count: expected none, got %0d", m_data.visited_count);
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                if (m_data.visited_count !== want.visited_count) begin
                    $error("visited_count: expected %0d, got %0d",
                           want.visited_count, m_data.visited_count);
                    mismatches++;
                end
                if (m_data.walk_error !== want.walk_error) begin
                    $error("walk_error: expected %0d, got %0d",
                           want.walk_error, m_data.walk_error);
                    mismatches++;
                end
            end
        end
    end

    initial begin : result_sink
        int stall;
        int taken;
        bit sink_burst;
        taken      = 0;
        sink_burst = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 15);
            // hold off long enough for the block to back up its input
            if (taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int             counted;
        tacc_pkg::in_t  item;
        tacc_pkg::out_t typed_count;
        foreach (tree_parent[i]) begin
            tree_parent[i]   = '0;
            parent_loaded[i] = 1'b0;
            node_marked[i]   = 1'b0;
        end
        node_marked[0] = 1'b1;
        mark_count     = tacc_pkg::COUNT_W'(1);
        chain_tip      = 0;

        directed_ops = '{
            '{tacc_pkg::REQ_LOAD,    10'd0,    10'd1023, 1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd0,    10'd0,    1'b1, 11'd1, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd1023, 10'd0,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd1023, 10'd0,    1'b1, 11'd2, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd1023, 10'd1023, 1'b1, 11'd2, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd1,    10'd0,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd2,    10'd1,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd3,    10'd2,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd3,    10'd0,    1'b1, 11'd5, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd5,    10'd5,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd5,    10'd0,    1'b1, 11'd5, 1'b1},
            '{tacc_pkg::REQ_LOAD,    10'd4,    10'd6,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd6,    10'd4,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd6,    10'd0,    1'b1, 11'd5, 1'b1},
            '{REQ_UNUSED,            10'd1023, 10'd1023, 1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_RESTART, 10'd0,    10'd0,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd3,    10'd0,    1'b1, 11'd4, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd1023, 10'd0,    1'b1, 11'd5, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd682,  10'd3,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_LOAD,    10'd341,  10'd682,  1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd341,  10'd0,    1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd2,    10'd0,    1'b1, 11'd7, 1'b0},
            '{tacc_pkg::REQ_RESTART, 10'd1023, 10'd1023, 1'b0, 11'd0, 1'b0},
            '{tacc_pkg::REQ_QUERY,   10'd0,    10'd0,    1'b1, 11'd1, 1'b0}
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_ops[i]) begin
            item.req_type              = directed_ops[i].req_type;
            item.node                  = directed_ops[i].node;
            item.parent_node           = directed_ops[i].parent_node;
            typed_count.visited_count  = directed_ops[i].visited_count;
            typed_count.walk_error     = directed_ops[i].walk_error;
            offer(item, directed_ops[i].typed, typed_count);
        end

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            pick_random_item(item);
            offer(item, 1'b0, '0);
            if (item.req_type != REQ_UNUSED) counted++;
        end
        s_valid <= 1'b0;

        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
